/* rtl/opqs_pkg.sv */
package opqs_pkg;

	// Q31 limits
	localparam logic signed [31:0] Q31_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] Q31_MIN = 32'sh8000_0000;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_COEFF = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NORM  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_THR   = 2'd2;

	// reset value of the snap threshold
	localparam logic [30:0] SNAP_THR_RESET = 31'h0000_4000;

	// request kinds
	typedef enum logic [1:0] {
		REQ_STEP   = 2'd0,
		REQ_TARGET = 2'd1,
		REQ_LOAD   = 2'd2,
		REQ_SYNC   = 2'd3
	} req_e;

	typedef struct packed {
		logic signed [31:0] coeff;
		logic               norm;
		logic [30:0]        thr;
	} cfg_t;

	typedef struct packed {
		req_e               req_type;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] filtered;
		logic               settled;
	} result_t;

endpackage

/* rtl/one_pole_q31_smoother_unit.sv */
// Channel  Dir  Fields (low bit up)                  Handshake
// s_axis   in   tuser: req_type[1:0]; tdata: value    tvalid/tready
// m_axis   out  tdata: filtered; tuser: settled       tvalid/tready
// cfg      in   cfg_index selects, cfg_wdata data      cfg_we, no wait
//
// One word per cycle while the result is not stalled; the result is registered.
// The target/output feedback runs through one pass of the core (subtract,
// normalize, 32x32 multiply, add) between the input and result registers.
// arst_n clears both levels and the valid flags, and sets the config registers
// to their reset values.
// A stalled result holds; s_axis_tready drops once the input register is
// also full, and a new word enters as soon as the result is taken.
module one_pole_q31_smoother_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_axis_tvalid,
	output logic                         s_axis_tready,
	input  logic [31:0]                  s_axis_tdata,  // value
	input  logic [1:0]                   s_axis_tuser,  // req_type
	output logic                         m_axis_tvalid,
	input  logic                         m_axis_tready,
	output logic [31:0]                  m_axis_tdata,  // filtered
	output logic                         m_axis_tuser,  // settled
	input  logic                         cfg_we,
	input  logic [opqs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                  cfg_wdata
);

	opqs_pkg::cfg_t    cfg;
	opqs_pkg::req_t    in_req;
	opqs_pkg::req_t    req_s1;
	opqs_pkg::result_t res;
	opqs_pkg::result_t res_q;
	logic              valid_s1;
	logic              out_valid_q;
	logic              adv;

	assign in_req.req_type = opqs_pkg::req_e'(s_axis_tuser);
	assign in_req.value    = $signed(s_axis_tdata);

	// held word moves into the result register when that is free
	assign adv = valid_s1 && (!out_valid_q || m_axis_tready);

	opqs_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	opqs_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_req   (in_req),
		.adv      (adv),
		.valid_s1 (valid_s1),
		.req_s1   (req_s1)
	);

	opqs_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (adv),
		.req    (req_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = res_q.filtered;
	assign m_axis_tuser  = res_q.settled;

`ifndef ASSERT_OFF
	// a load item shows its value as the next result
	a_load_value: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && req_s1.req_type == opqs_pkg::REQ_LOAD)
		|=> (m_axis_tdata == $past(req_s1.value)))
		else $error("loaded value not returned");

	// settled is reported only for sync items
	a_settled_sync: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && req_s1.req_type != opqs_pkg::REQ_SYNC) |=> !m_axis_tuser)
		else $error("settled set outside sync");

	// a held input word is never lost while the result side stalls
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !adv) |=> (valid_s1 && $stable(req_s1)))
		else $error("input word dropped");

	// no new word taken when both registers are full and stalled
	a_full_block: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_axis_tready) |-> !s_axis_tready)
		else $error("word accepted while full");
`endif

endmodule

/* rtl/opqs_cfg.sv */
module opqs_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [opqs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                  cfg_wdata,
	output opqs_pkg::cfg_t               cfg
);

	opqs_pkg::cfg_t cfg_q;

	// register file, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.coeff <= '0;
			cfg_q.norm  <= 1'b0;
			cfg_q.thr   <= opqs_pkg::SNAP_THR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				opqs_pkg::CFG_COEFF: cfg_q.coeff <= $signed(cfg_wdata);
				opqs_pkg::CFG_NORM:  cfg_q.norm  <= cfg_wdata[0];
				opqs_pkg::CFG_THR:   cfg_q.thr   <= cfg_wdata[30:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/opqs_in_stage.sv */
module opqs_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  opqs_pkg::req_t      in_req,
	input  logic                adv,
	output logic                valid_s1,
	output opqs_pkg::req_t      req_s1
);

	logic           vld_s1;
	opqs_pkg::req_t data_s1;

	// takes a word when empty or when the held one moves on this cycle
	assign in_ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ready) begin
			vld_s1 <= in_valid;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1 <= in_req;
		end
	end

	assign valid_s1 = vld_s1;
	assign req_s1   = data_s1;

endmodule

/* rtl/opqs_core.sv */
module opqs_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                go,
	input  opqs_pkg::req_t      req,
	input  opqs_pkg::cfg_t      cfg,
	output opqs_pkg::result_t   res
);

	logic signed [31:0] target_q;
	logic signed [31:0] output_q;

	logic signed [32:0] diff_w;
	logic signed [31:0] diff;
	logic [31:0]        mag;
	logic [4:0]         rsb;
	logic [4:0]         shamt;
	logic signed [31:0] scaled;
	logic signed [63:0] prod;
	logic signed [31:0] mul_q31;
	logic signed [31:0] delta;
	logic signed [32:0] sum_w;
	logic signed [31:0] step_out;
	logic signed [32:0] sdiff_w;
	logic signed [31:0] sdiff;
	logic signed [31:0] sneg;
	logic [30:0]        sabs;
	logic               equal;
	logic               near;
	logic signed [31:0] target_nx;
	logic signed [31:0] output_nx;
	logic               settled_nx;

	function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
		logic signed [31:0] r;
		if (v[32] != v[31]) begin
			r = v[32] ? opqs_pkg::Q31_MIN : opqs_pkg::Q31_MAX;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// leading zeros of a 32-bit word with a forced low one, five halving steps
	function automatic logic [4:0] clz32(input logic [31:0] x);
		logic [31:0] t;
		logic [4:0]  n;
		t = x;
		n = '0;
		if (t[31:16] == '0) begin n[4] = 1'b1; t = t << 16; end
		if (t[31:24] == '0) begin n[3] = 1'b1; t = t << 8;  end
		if (t[31:28] == '0) begin n[2] = 1'b1; t = t << 4;  end
		if (t[31:30] == '0) begin n[1] = 1'b1; t = t << 2;  end
		if (t[31] == 1'b0)  begin n[0] = 1'b1; end
		return n;
	endfunction

	// step: output - target, optionally normalized, times coeff, plus target
	always_comb begin
		diff_w = {output_q[31], output_q} - {target_q[31], target_q};
		diff   = sat33(diff_w);
		mag    = diff[31] ? ~diff : diff;
		rsb    = clz32({mag[30:0], 1'b1});
		shamt  = cfg.norm ? rsb : 5'd0;
		// shifting by the redundant sign count never overflows
		scaled = diff <<< shamt;
		prod   = cfg.coeff * scaled;
		// only -1 * -1 leaves range, and that saturates high
		mul_q31  = (prod[63] != prod[62]) ? opqs_pkg::Q31_MAX : prod[62:31];
		delta    = mul_q31 >>> shamt;
		sum_w    = {target_q[31], target_q} + {delta[31], delta};
		step_out = sat33(sum_w);
	end

	// sync test: saturating |target - output| against the threshold
	always_comb begin
		sdiff_w = {target_q[31], target_q} - {output_q[31], output_q};
		sdiff   = sat33(sdiff_w);
		sneg    = -sdiff;
		if (!sdiff[31]) begin
			sabs = sdiff[30:0];
		end else if (sdiff == opqs_pkg::Q31_MIN) begin
			sabs = opqs_pkg::Q31_MAX[30:0];
		end else begin
			sabs = sneg[30:0];
		end
		equal = (target_q == output_q);
		near  = (sabs < cfg.thr);
	end

	// next state by request kind
	always_comb begin
		target_nx  = target_q;
		output_nx  = output_q;
		settled_nx = 1'b0;
		case (req.req_type)
			opqs_pkg::REQ_STEP:   output_nx = step_out;
			opqs_pkg::REQ_TARGET: target_nx = req.value;
			opqs_pkg::REQ_LOAD:   output_nx = req.value;
			opqs_pkg::REQ_SYNC: begin
				if (equal) begin
					settled_nx = 1'b1;
				end else if (near) begin
					output_nx = target_q;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			output_q <= '0;
		end else if (go) begin
			target_q <= target_nx;
			output_q <= output_nx;
		end
	end

	assign res.filtered = output_nx;
	assign res.settled  = settled_nx;

endmodule

/* tb/sv/opqs_smoother_checker.sv */
`timescale 1ns / 100ps

module opqs_smoother_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	input  logic                           s_axis_tready,
	input  logic [31:0]                    s_axis_tdata,  // value
	input  logic [1:0]                     s_axis_tuser,  // req_type
	input  logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	input  logic [31:0]                    m_axis_tdata,  // filtered
	input  logic                           m_axis_tuser,  // settled
	input  logic                           cfg_we,
	input  logic [opqs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_wdata,
	output int                             mismatches,
	output int                             outstanding,
	output int                             results_seen
);
	import opqs_pkg::*;

	// shadow of the block's registers and levels
	logic signed [31:0] coeff_q31;
	logic               norm_on;
	logic [30:0]        snap_thr;
	logic signed [31:0] tgt_lvl;
	logic signed [31:0] out_lvl;

	result_t expected_words[$];
	result_t want;
	result_t got;

	function automatic logic signed [31:0] clamp_q31(input longint v);
		if (v > longint'(Q31_MAX))
			return Q31_MAX;
		if (v < longint'(Q31_MIN))
			return Q31_MIN;
		return v[31:0];
	endfunction

	// Q31 product, floor rounding; only MIN*MIN clips
	function automatic logic signed [31:0] mul_q31(input logic signed [31:0] a,
			input logic signed [31:0] b);
		longint prod;
		prod = longint'(a) * longint'(b);
		return clamp_q31(prod >>> 31);
	endfunction

	// leading bits equal to the sign, minus one; 0 and -1 give 31
	function automatic int sign_bits(input logic signed [31:0] d);
		logic [31:0] u;
		int          n;
		u = d[31] ? ~d : d;
		n = 0;
		while (n < 31 && !u[30]) begin
			u = u << 1;
			n++;
		end
		return n;
	endfunction

	// advance the shadow levels by one word and return the result it yields
	function automatic result_t predict_smoother(input req_e kind,
			input logic signed [31:0] v);
		result_t            r;
		logic signed [31:0] diff;
		logic signed [31:0] scaled;
		logic signed [31:0] prod;
		logic signed [31:0] delta;
		logic signed [31:0] gap;
		logic signed [31:0] mag;
		int                 sh;
		r.settled = 1'b0;
		case (kind)
			REQ_STEP: begin
				diff = clamp_q31(longint'(out_lvl) - longint'(tgt_lvl));
				if (norm_on) begin
					sh = sign_bits(diff);
					scaled = clamp_q31(longint'(diff) <<< sh);
					prod = mul_q31(coeff_q31, scaled);
					delta = prod >>> sh;
				end else begin
					delta = mul_q31(coeff_q31, diff);
				end
				out_lvl = clamp_q31(longint'(tgt_lvl) + longint'(delta));
			end
			REQ_TARGET: tgt_lvl = v;
			REQ_LOAD: out_lvl = v;
			default: begin
				if (tgt_lvl == out_lvl) begin
					r.settled = 1'b1;
				end else begin
					gap = clamp_q31(longint'(tgt_lvl) - longint'(out_lvl));
					if (gap == Q31_MIN)
						mag = Q31_MAX;
					else if (gap < 0)
						mag = -gap;
					else
						mag = gap;
					// snap only when strictly inside the threshold
					if (longint'(mag) < longint'(snap_thr))
						out_lvl = tgt_lvl;
				end
			end
		endcase
		r.filtered = out_lvl;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q31 = '0;
			norm_on = 1'b0;
			snap_thr = SNAP_THR_RESET;
			tgt_lvl = '0;
			out_lvl = '0;
			expected_words.delete();
			mismatches = 0;
			outstanding = 0;
			results_seen = 0;
		end else begin
			// register writes
			if (cfg_we) begin
				case (cfg_index)
					CFG_COEFF: coeff_q31 = cfg_wdata;
					CFG_NORM: norm_on = cfg_wdata[0];
					CFG_THR: snap_thr = cfg_wdata[30:0];
					default: ;
				endcase
			end

			// result side: compare against oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				got.filtered = m_axis_tdata;
				got.settled = m_axis_tuser;
				results_seen++;
				if (expected_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected result word: filtered %h settled %0d",
							got.filtered, got.settled);
				end else begin
					want = expected_words.pop_front();
					if (got.filtered !== want.filtered || got.settled !== want.settled) begin
						mismatches++;
						if (mismatches <= 10)
							$display("result %0d: filtered exp %h got %h, settled exp %0d got %0d",
								results_seen, want.filtered, got.filtered,
								want.settled, got.settled);
					end
				end
			end

			// input side: predict
			if (s_axis_tvalid && s_axis_tready)
				expected_words.push_back(predict_smoother(req_e'(s_axis_tuser), s_axis_tdata));

			outstanding = expected_words.size();
		end
	end

endmodule

/* tb/sv/one_pole_q31_smoother_unit_tb.sv */
`timescale 1ns / 100ps

module one_pole_q31_smoother_unit_tb;
	import opqs_pkg::*;

	// index with no register behind it, writes must be dropped
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [31:0]          s_axis_tdata = '0;   // value
	logic [1:0]           s_axis_tuser = '0;   // req_type
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [31:0]          m_axis_tdata;        // filtered
	logic                 m_axis_tuser;        // settled
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]          cfg_wdata = '0;

	int mismatches;
	int outstanding;
	int results_seen;

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int stall_left = 0;
	int items_sent = 0;
	int reg_writes = 0;
	logic [31:0] last_tgt = '0;

	one_pole_q31_smoother_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	opqs_smoother_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.results_seen(results_seen)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// result side backpressure; a long hold counts down here
	always @(posedge clk) begin
		if (stall_left > 0) begin
			m_axis_tready <= 1'b0;
			stall_left--;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	initial begin
		#400000;
		$display("one_pole_q31_smoother_unit_tb NOT OK");
		$finish;
	end

	// offer one word, idle first at random, return once accepted
	task automatic push_word(input req_e kind, input logic [31:0] v);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		s_axis_tuser <= kind;
		do
			@(posedge clk);
		while (!s_axis_tready);
		items_sent++;
		if (kind == REQ_TARGET)
			last_tgt = v;
	endtask

	// stop sending and let every predicted result come back
	task automatic settle_out();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// write all registers plus the unused index, back to back
	task automatic load_regs(input logic [31:0] coeff, input logic norm,
			input logic [30:0] thr);
		logic [31:0] junk;
		junk = $urandom;
		cfg_we <= 1'b1;
		cfg_index <= CFG_COEFF;
		cfg_wdata <= coeff;
		@(posedge clk);
		cfg_index <= CFG_NORM;
		cfg_wdata <= {junk[31:1], norm};
		@(posedge clk);
		cfg_index <= CFG_SPARE;
		cfg_wdata <= $urandom;
		@(posedge clk);
		cfg_index <= CFG_THR;
		cfg_wdata <= {junk[0], thr};
		@(posedge clk);
		cfg_we <= 1'b0;
		reg_writes += 4;
	endtask

	function automatic logic [31:0] pick_level();
		case ($urandom_range(9))
			0: return Q31_MAX;
			1: return Q31_MIN;
			2: return 32'd0;
			3: return 32'hFFFF_FFFF;
			4, 5: return last_tgt + $urandom_range(40000) - 32'd20000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_coeff();
		case ($urandom_range(6))
			0: return Q31_MAX;
			1: return Q31_MIN;
			2: return 32'd0;
			3, 4: return {8'h7F, 24'($urandom)};  // slow approach, near one
			5: return {8'h80, 24'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [30:0] pick_thr();
		case ($urandom_range(5))
			0: return 31'd0;
			1: return 31'h7FFF_FFFF;
			2: return SNAP_THR_RESET;
			3, 4: return 31'($urandom_range(1 << 20));
			default: return 31'($urandom);
		endcase
	endfunction

	// mostly target/load then a run of steps and syncs, some noise
	task automatic run_phase(input int n, input int tx_pct, input int rx_pct);
		int first;
		int cfg_mark;
		int steps;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		first = items_sent;
		cfg_mark = items_sent;
		settle_out();
		load_regs(pick_coeff(), 1'($urandom_range(1)), pick_thr());
		while (items_sent - first < n) begin
			if (items_sent - cfg_mark >= 110) begin
				settle_out();
				load_regs(pick_coeff(), 1'($urandom_range(1)), pick_thr());
				cfg_mark = items_sent;
			end
			if ($urandom_range(9) < 8) begin
				push_word(REQ_TARGET, pick_level());
				if ($urandom_range(1))
					push_word(REQ_LOAD, pick_level());
				steps = $urandom_range(12, 1);
				repeat (steps)
					push_word(($urandom_range(3) == 0) ? REQ_SYNC : REQ_STEP, $urandom);
				push_word(REQ_SYNC, $urandom);
			end else begin
				push_word(req_e'($urandom_range(3)), $urandom);
			end
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		tx_idle_pct = 24;
		rx_idle_pct = 78;

		// reset settings: coeff 0 lands on the target in one step
		push_word(REQ_STEP, 32'hDEAD_BEEF);
		push_word(REQ_TARGET, Q31_MAX);
		push_word(REQ_LOAD, Q31_MIN);
		push_word(REQ_SYNC, 32'h1234_5678);  // far apart, abs clips
		push_word(REQ_STEP, 32'h0);
		push_word(REQ_SYNC, 32'hFFFF_FFFF);  // equal now
		push_word(REQ_LOAD, Q31_MAX - 32'd100);
		push_word(REQ_SYNC, 32'h0);          // near: snaps
		push_word(REQ_SYNC, 32'h0);
		settle_out();

		// coeff -1, normalized, zero threshold
		load_regs(Q31_MIN, 1'b1, 31'd0);
		push_word(REQ_TARGET, 32'd0);
		push_word(REQ_LOAD, Q31_MIN);
		push_word(REQ_STEP, 32'h5555_5555);  // -1 * -1 clips
		push_word(REQ_LOAD, 32'hFFFF_FFFF);
		push_word(REQ_STEP, 32'h0);
		push_word(REQ_LOAD, 32'd1);
		push_word(REQ_SYNC, 32'h0);          // zero threshold never snaps
		push_word(REQ_TARGET, 32'd1);
		push_word(REQ_SYNC, 32'h0);
		settle_out();

		// coeff max, plain multiply, widest threshold
		load_regs(Q31_MAX, 1'b0, 31'h7FFF_FFFF);
		push_word(REQ_TARGET, Q31_MIN);
		push_word(REQ_LOAD, Q31_MAX);
		push_word(REQ_STEP, 32'h0);
		push_word(REQ_STEP, 32'h0);
		push_word(REQ_SYNC, 32'h0);
		push_word(REQ_SYNC, 32'h0);

		// long output stall with the input side pushing hard
		tx_idle_pct = 0;
		stall_left = 80;
		push_word(REQ_TARGET, 32'h4000_0000);
		repeat (19)
			push_word(REQ_STEP, $urandom);
		settle_out();

		run_phase(330, 24, 78);
		run_phase(330, 78, 24);
		run_phase(340, 0, 0);
		settle_out();

		$display("sent %0d words (all request kinds, extremes, near and far syncs)",
			items_sent);
		$display("checked %0d results over %0d register writes and three stall mixes",
			results_seen, reg_writes);
		if (mismatches == 0 && outstanding == 0) begin
			$display("one_pole_q31_smoother_unit_tb OK");
		end else begin
			$display("one_pole_q31_smoother_unit_tb NOT OK");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/opqs_pkg.sv
rtl/opqs_cfg.sv
rtl/opqs_in_stage.sv
rtl/opqs_core.sv
rtl/one_pole_q31_smoother_unit.sv
tb/sv/opqs_smoother_checker.sv
tb/sv/one_pole_q31_smoother_unit_tb.sv
